[rtl/source_token_scanner_top_defines.svh]
// Assertion helpers for the token scanner checker.
`ifndef SOURCE_TOKEN_SCANNER_TOP_DEFINES_SVH
`define SOURCE_TOKEN_SCANNER_TOP_DEFINES_SVH

// Same-cycle implication, inactive while reset is high.
`define STS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, inactive while reset is high.
`define STS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/sts_pkg.sv]
`default_nettype none

package sts_pkg;

   localparam int TOKEN_FIELD_W = 20;
   localparam int LINE_W        = 16;
   localparam int KIND_W        = 5;
   localparam int ERR_W         = 2;
   localparam int MAX_RESULTS   = 3;

   localparam logic [TOKEN_FIELD_W-1:0] FIELD_MAX = '1;
   localparam logic [LINE_W-1:0]        LINE_MAX  = '1;

   // token kinds
   localparam logic [KIND_W-1:0] K_LEFT_PAREN    = 5'd0;
   localparam logic [KIND_W-1:0] K_RIGHT_PAREN   = 5'd1;
   localparam logic [KIND_W-1:0] K_LEFT_BRACE    = 5'd2;
   localparam logic [KIND_W-1:0] K_RIGHT_BRACE   = 5'd3;
   localparam logic [KIND_W-1:0] K_COMMA         = 5'd4;
   localparam logic [KIND_W-1:0] K_MINUS         = 5'd5;
   localparam logic [KIND_W-1:0] K_PLUS          = 5'd6;
   localparam logic [KIND_W-1:0] K_SEMICOLON     = 5'd7;
   localparam logic [KIND_W-1:0] K_COLON         = 5'd8;
   localparam logic [KIND_W-1:0] K_STAR          = 5'd9;
   localparam logic [KIND_W-1:0] K_SLASH         = 5'd10;
   localparam logic [KIND_W-1:0] K_BANG          = 5'd11;
   localparam logic [KIND_W-1:0] K_BANG_EQUAL    = 5'd12;
   localparam logic [KIND_W-1:0] K_EQUAL         = 5'd13;
   localparam logic [KIND_W-1:0] K_EQUAL_EQUAL   = 5'd14;
   localparam logic [KIND_W-1:0] K_LESS          = 5'd15;
   localparam logic [KIND_W-1:0] K_LESS_EQUAL    = 5'd16;
   localparam logic [KIND_W-1:0] K_GREATER       = 5'd17;
   localparam logic [KIND_W-1:0] K_GREATER_EQUAL = 5'd18;
   localparam logic [KIND_W-1:0] K_STRING        = 5'd19;
   localparam logic [KIND_W-1:0] K_NUMBER        = 5'd20;
   localparam logic [KIND_W-1:0] K_IDENT         = 5'd21;
   localparam logic [KIND_W-1:0] K_ELSE          = 5'd22;
   localparam logic [KIND_W-1:0] K_FUN           = 5'd23;
   localparam logic [KIND_W-1:0] K_IF            = 5'd24;
   localparam logic [KIND_W-1:0] K_RETURN        = 5'd25;
   localparam logic [KIND_W-1:0] K_VAR           = 5'd26;
   localparam logic [KIND_W-1:0] K_NUMBER_TYPE   = 5'd27;
   localparam logic [KIND_W-1:0] K_STRING_TYPE   = 5'd28;
   localparam logic [KIND_W-1:0] K_EOF           = 5'd29;
   localparam logic [KIND_W-1:0] K_NONE          = 5'd30;

   // error codes
   localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
   localparam logic [ERR_W-1:0] ERR_UNEXPECTED = 2'd1;
   localparam logic [ERR_W-1:0] ERR_UNTERM_STR = 2'd2;

   // pending operator codes
   localparam logic [2:0] OP_BANG    = 3'd0;
   localparam logic [2:0] OP_EQUAL   = 3'd1;
   localparam logic [2:0] OP_LESS    = 3'd2;
   localparam logic [2:0] OP_GREATER = 3'd3;
   localparam logic [2:0] OP_SLASH   = 3'd4;

   // characters
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_NL      = 8'h0A;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_BANG    = 8'h21;
   localparam logic [7:0] CHAR_QUOTE   = 8'h22;
   localparam logic [7:0] CHAR_LPAREN  = 8'h28;
   localparam logic [7:0] CHAR_RPAREN  = 8'h29;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_LESS    = 8'h3C;
   localparam logic [7:0] CHAR_EQUAL   = 8'h3D;
   localparam logic [7:0] CHAR_GREATER = 8'h3E;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_LBRACE  = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE  = 8'h7D;

   // keywords, first character in the low byte
   localparam int NUM_KEYWORDS = 7;
   localparam logic [63:0] KW_TEXT [NUM_KEYWORDS] = '{
      64'h0000_0000_6573_6C65,   // else
      64'h0000_0000_006E_7566,   // fun
      64'h0000_0000_0000_6669,   // if
      64'h0000_6E72_7574_6572,   // return
      64'h0000_0000_0072_6176,   // var
      64'h0000_7265_626D_756E,   // number
      64'h0000_676E_6972_7473    // string
   };
   localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
      4'd4, 4'd3, 4'd2, 4'd6, 4'd3, 4'd6, 4'd6
   };
   localparam logic [KIND_W-1:0] KW_KIND [NUM_KEYWORDS] = '{
      K_ELSE, K_FUN, K_IF, K_RETURN, K_VAR, K_NUMBER_TYPE, K_STRING_TYPE
   };

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_OPER,
      MODE_COMMENT,
      MODE_STRING,
      MODE_NUM_INT,
      MODE_NUM_DOT,
      MODE_NUM_FRAC,
      MODE_WORD
   } scan_mode_type;

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic [TOKEN_FIELD_W-1:0] start;
      logic [TOKEN_FIELD_W-1:0] length;
      logic [ERR_W-1:0]         err;
   } result_type;

   // all results caused by one input transaction
   typedef struct packed {
      logic [1:0]                   count;
      logic [LINE_W-1:0]            line;
      result_type [MAX_RESULTS-1:0] res;
   } bundle_type;

   function automatic logic [KIND_W-1:0] op_single_kind(input logic [2:0] op);
      logic [KIND_W-1:0] k;
      unique case (op)
         OP_BANG:    k = K_BANG;
         OP_EQUAL:   k = K_EQUAL;
         OP_LESS:    k = K_LESS;
         OP_GREATER: k = K_GREATER;
         default:    k = K_SLASH;
      endcase
      return k;
   endfunction

   function automatic logic [KIND_W-1:0] op_double_kind(input logic [2:0] op);
      logic [KIND_W-1:0] k;
      unique case (op)
         OP_BANG:    k = K_BANG_EQUAL;
         OP_EQUAL:   k = K_EQUAL_EQUAL;
         OP_LESS:    k = K_LESS_EQUAL;
         OP_GREATER: k = K_GREATER_EQUAL;
         default:    k = K_SLASH;
      endcase
      return k;
   endfunction

   function automatic logic [KIND_W-1:0] keyword_kind(input logic [63:0] prefix,
                                                      input logic [3:0]  len);
      logic [KIND_W-1:0] k;
      k = K_IDENT;
      for (int i = 0; i < NUM_KEYWORDS; i++) begin
         if (len == KW_LEN[i] && prefix == KW_TEXT[i]) begin
            k = KW_KIND[i];
         end
      end
      return k;
   endfunction

endpackage

`default_nettype wire

[rtl/source_token_scanner_top.sv]
// Channel   Direction  Handshake               Payload
// req_      in         req_tvalid/req_tready   tdata: source byte; tlast: end of source
// rsp_      out        rsp_tvalid/rsp_tready   tdata: start, length, line; tuser: kind,
//                                              error; tlast: last result of the input
//
// One source byte is taken every clock while the queue is not full; the scan mode
// register is updated as each byte is taken. A byte that yields two or three tokens
// holds the result port until all of them are sent; a four-entry queue between the
// scanner and the output stage absorbs such bursts, and req_tready drops only while
// it is full. Each result passes through the queue and the output register in turn.
// Reset is synchronous: offset 0, line 1, queue and output register empty.
`default_nettype none

module source_token_scanner_top
   import sts_pkg::*;
#(
   parameter int MAX_SOURCE_BYTES  = 1048576,
   parameter int MAX_KEYWORD_CHARS = 6
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] source_byte
   input  wire logic        req_tlast,   // end_of_source
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // [19:0] token_start, [39:20] token_length,
                                         // [55:40] line_number
   output logic [6:0]       rsp_tuser,   // [4:0] token_kind, [6:5] error_code
   output logic             rsp_tlast    // last_of_run
);

   logic       push_valid;
   bundle_type push_bundle;
   logic       queue_full;
   logic       head_valid;
   bundle_type head_bundle;
   logic       pop;

   sts_front #(
      .MAX_SOURCE_BYTES  (MAX_SOURCE_BYTES),
      .MAX_KEYWORD_CHARS (MAX_KEYWORD_CHARS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_byte     (req_tdata),
      .in_end      (req_tlast),
      .in_ready    (req_tready),
      .queue_full  (queue_full),
      .push_valid  (push_valid),
      .push_bundle (push_bundle)
   );

   sts_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_bundle (push_bundle),
      .full        (queue_full),
      .head_valid  (head_valid),
      .head_bundle (head_bundle),
      .pop         (pop)
   );

   sts_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_bundle (head_bundle),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

`default_nettype wire

[rtl/sts_front.sv]
`default_nettype none

module sts_front
   import sts_pkg::*;
#(
   parameter int MAX_SOURCE_BYTES  = 1048576,
   parameter int MAX_KEYWORD_CHARS = 6
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   input  wire logic [7:0] in_byte,
   input  wire logic       in_end,
   output logic            in_ready,
   input  wire logic       queue_full,
   output logic            push_valid,
   output bundle_type      push_bundle
);

   localparam int PW = $clog2(MAX_SOURCE_BYTES + 2);
   localparam int KW = 8 * MAX_KEYWORD_CHARS;
   localparam int LW = $clog2(MAX_KEYWORD_CHARS + 2);
   localparam int XW = (PW > TOKEN_FIELD_W) ? PW : TOKEN_FIELD_W;

   typedef enum logic [2:0] {
      CLS_PUNCT,
      CLS_OPER,
      CLS_QUOTE,
      CLS_SPACE,
      CLS_NEWLINE,
      CLS_DIGIT,
      CLS_ALPHA,
      CLS_OTHER
   } char_class_type;

   scan_mode_type     mode_ff, mode_in;
   logic [2:0]        pend_ff, pend_in;
   logic [PW-1:0]     lex_start_ff, lex_start_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [KW-1:0]     prefix_ff, prefix_in;
   logic [LW-1:0]     wlen_ff, wlen_in;

   char_class_type    cls;
   logic [KIND_W-1:0] punct_kind;
   logic [2:0]        oper_code;
   logic              accept;
   logic              taken;
   logic              is_digit, is_alpha;
   logic [KIND_W-1:0] word_kind;
   logic              line_up;
   logic              a0_v, a1_v, b_v;
   result_type        a0, a1, b;

   function automatic logic [TOKEN_FIELD_W-1:0] sat_field(input logic [PW-1:0] x);
      logic [XW-1:0] ext;
      ext = XW'(x);
      return (ext > XW'(FIELD_MAX)) ? FIELD_MAX : ext[TOKEN_FIELD_W-1:0];
   endfunction

   function automatic logic [PW-1:0] span(input logic [PW-1:0] e, input logic [PW-1:0] s);
      return (e >= s) ? e - s : '0;
   endfunction

   function automatic result_type make_res(input logic [KIND_W-1:0] kind,
                                           input logic [PW-1:0]     start,
                                           input logic [PW-1:0]     len,
                                           input logic [ERR_W-1:0]  err);
      result_type r;
      r.kind   = kind;
      r.start  = sat_field(start);
      r.length = sat_field(len);
      r.err    = err;
      return r;
   endfunction

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;
   assign is_digit = (cls == CLS_DIGIT);
   assign is_alpha = (cls == CLS_ALPHA);

   // words longer than the keyword window are always identifiers
   assign word_kind = (wlen_ff <= LW'(MAX_KEYWORD_CHARS)) ?
                      keyword_kind(64'(prefix_ff), 4'(wlen_ff)) : K_IDENT;

   // character class decoder
   always_comb begin
      cls        = CLS_OTHER;
      punct_kind = K_NONE;
      oper_code  = OP_BANG;
      unique case (in_byte) inside
         CHAR_LPAREN:  begin cls = CLS_PUNCT; punct_kind = K_LEFT_PAREN;  end
         CHAR_RPAREN:  begin cls = CLS_PUNCT; punct_kind = K_RIGHT_PAREN; end
         CHAR_LBRACE:  begin cls = CLS_PUNCT; punct_kind = K_LEFT_BRACE;  end
         CHAR_RBRACE:  begin cls = CLS_PUNCT; punct_kind = K_RIGHT_BRACE; end
         CHAR_COMMA:   begin cls = CLS_PUNCT; punct_kind = K_COMMA;       end
         CHAR_MINUS:   begin cls = CLS_PUNCT; punct_kind = K_MINUS;       end
         CHAR_PLUS:    begin cls = CLS_PUNCT; punct_kind = K_PLUS;        end
         CHAR_SEMI:    begin cls = CLS_PUNCT; punct_kind = K_SEMICOLON;   end
         CHAR_COLON:   begin cls = CLS_PUNCT; punct_kind = K_COLON;       end
         CHAR_STAR:    begin cls = CLS_PUNCT; punct_kind = K_STAR;        end
         CHAR_BANG:    begin cls = CLS_OPER;  oper_code  = OP_BANG;       end
         CHAR_EQUAL:   begin cls = CLS_OPER;  oper_code  = OP_EQUAL;      end
         CHAR_LESS:    begin cls = CLS_OPER;  oper_code  = OP_LESS;       end
         CHAR_GREATER: begin cls = CLS_OPER;  oper_code  = OP_GREATER;    end
         CHAR_SLASH:   begin cls = CLS_OPER;  oper_code  = OP_SLASH;      end
         CHAR_QUOTE:   cls = CLS_QUOTE;
         CHAR_SPACE, CHAR_CR, CHAR_TAB: cls = CLS_SPACE;
         CHAR_NL:      cls = CLS_NEWLINE;
         [CHAR_ZERO:CHAR_NINE]: cls = CLS_DIGIT;
         [CHAR_UPPER_A:CHAR_UPPER_Z], [CHAR_LOWER_A:CHAR_LOWER_Z]: cls = CLS_ALPHA;
         default:      cls = CLS_OTHER;
      endcase
   end

   // does the open lexeme consume this byte
   always_comb begin
      unique case (mode_ff)
         MODE_OPER:     taken = (pend_ff != OP_SLASH && in_byte == CHAR_EQUAL) ||
                                (pend_ff == OP_SLASH && in_byte == CHAR_SLASH);
         MODE_COMMENT:  taken = (in_byte != CHAR_NL);
         MODE_STRING:   taken = 1'b1;
         MODE_NUM_INT:  taken = is_digit || in_byte == CHAR_DOT;
         MODE_NUM_DOT:  taken = is_digit;
         MODE_NUM_FRAC: taken = is_digit;
         MODE_WORD:     taken = is_digit || is_alpha;
         default:       taken = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      mode_in = mode_ff;
      if (accept) begin
         if (in_end) begin
            mode_in = MODE_IDLE;
         end else if (taken) begin
            unique case (mode_ff)
               MODE_OPER:    mode_in = (in_byte == CHAR_EQUAL) ? MODE_IDLE : MODE_COMMENT;
               MODE_STRING:  mode_in = (in_byte == CHAR_QUOTE) ? MODE_IDLE : MODE_STRING;
               MODE_NUM_INT: mode_in = (in_byte == CHAR_DOT) ? MODE_NUM_DOT : MODE_NUM_INT;
               MODE_NUM_DOT: mode_in = MODE_NUM_FRAC;
               default:      mode_in = mode_ff;
            endcase
         end else begin
            unique case (cls)
               CLS_OPER:  mode_in = MODE_OPER;
               CLS_QUOTE: mode_in = MODE_STRING;
               CLS_DIGIT: mode_in = MODE_NUM_INT;
               CLS_ALPHA: mode_in = MODE_WORD;
               default:   mode_in = MODE_IDLE;
            endcase
         end
      end
   end

   // results and lexeme bookkeeping
   always_comb begin
      a0_v         = 1'b0;
      a1_v         = 1'b0;
      b_v          = 1'b0;
      a0           = '0;
      a1           = '0;
      b            = '0;
      line_up      = 1'b0;
      pend_in      = pend_ff;
      lex_start_in = lex_start_ff;
      pos_in       = pos_ff;
      prefix_in    = prefix_ff;
      wlen_in      = wlen_ff;

      if (in_end) begin
         unique case (mode_ff)
            MODE_OPER: begin
               a0_v = 1'b1;
               a0   = make_res(op_single_kind(pend_ff), lex_start_ff, PW'(1), ERR_NONE);
            end
            MODE_STRING: begin
               a0_v = 1'b1;
               a0   = make_res(K_NONE, lex_start_ff, span(pos_ff, lex_start_ff),
                               ERR_UNTERM_STR);
            end
            MODE_NUM_INT, MODE_NUM_FRAC: begin
               a0_v = 1'b1;
               a0   = make_res(K_NUMBER, lex_start_ff, span(pos_ff, lex_start_ff),
                               ERR_NONE);
            end
            MODE_NUM_DOT: begin
               a0_v = 1'b1;
               a0   = make_res(K_NUMBER, lex_start_ff,
                               span(pos_ff - 1'b1, lex_start_ff), ERR_NONE);
               a1_v = 1'b1;
               a1   = make_res(K_NONE, pos_ff - 1'b1, PW'(1), ERR_UNEXPECTED);
            end
            MODE_WORD: begin
               a0_v = 1'b1;
               a0   = make_res(word_kind, lex_start_ff, span(pos_ff, lex_start_ff),
                               ERR_NONE);
            end
            default: ;
         endcase
         b_v          = 1'b1;
         b            = make_res(K_EOF, pos_ff, '0, ERR_NONE);
         pend_in      = OP_BANG;
         lex_start_in = '0;
         pos_in       = '0;
         prefix_in    = '0;
         wlen_in      = '0;
      end else begin
         unique case (mode_ff)
            MODE_OPER: begin
               if (pend_ff != OP_SLASH && in_byte == CHAR_EQUAL) begin
                  a0_v = 1'b1;
                  a0   = make_res(op_double_kind(pend_ff), lex_start_ff, PW'(2), ERR_NONE);
               end else if (!taken) begin
                  a0_v = 1'b1;
                  a0   = make_res(op_single_kind(pend_ff), lex_start_ff, PW'(1), ERR_NONE);
               end
            end
            MODE_STRING: begin
               if (in_byte == CHAR_QUOTE) begin
                  a0_v = 1'b1;
                  a0   = make_res(K_STRING, lex_start_ff, span(pos_ff, lex_start_ff),
                                  ERR_NONE);
               end else if (in_byte == CHAR_NL) begin
                  line_up = 1'b1;
               end
            end
            MODE_NUM_INT, MODE_NUM_FRAC: begin
               if (!taken) begin
                  a0_v = 1'b1;
                  a0   = make_res(K_NUMBER, lex_start_ff, span(pos_ff, lex_start_ff),
                                  ERR_NONE);
               end
            end
            MODE_NUM_DOT: begin
               // dot not followed by a digit: number without it, then the dot as error
               if (!taken) begin
                  a0_v = 1'b1;
                  a0   = make_res(K_NUMBER, lex_start_ff,
                                  span(pos_ff - 1'b1, lex_start_ff), ERR_NONE);
                  a1_v = 1'b1;
                  a1   = make_res(K_NONE, pos_ff - 1'b1, PW'(1), ERR_UNEXPECTED);
               end
            end
            MODE_WORD: begin
               if (taken) begin
                  if (wlen_ff < LW'(MAX_KEYWORD_CHARS)) begin
                     prefix_in[8*wlen_ff +: 8] = in_byte;
                     wlen_in = wlen_ff + 1'b1;
                  end else begin
                     wlen_in = LW'(MAX_KEYWORD_CHARS + 1);
                  end
               end else begin
                  a0_v = 1'b1;
                  a0   = make_res(word_kind, lex_start_ff, span(pos_ff, lex_start_ff),
                                  ERR_NONE);
               end
            end
            default: ;
         endcase

         if (!taken) begin
            unique case (cls)
               CLS_PUNCT: begin
                  b_v = 1'b1;
                  b   = make_res(punct_kind, pos_ff, PW'(1), ERR_NONE);
               end
               CLS_OPER: begin
                  pend_in      = oper_code;
                  lex_start_in = pos_ff;
               end
               CLS_QUOTE:   lex_start_in = pos_ff + 1'b1;
               CLS_NEWLINE: line_up = 1'b1;
               CLS_DIGIT:   lex_start_in = pos_ff;
               CLS_ALPHA: begin
                  lex_start_in = pos_ff;
                  prefix_in    = KW'(in_byte);
                  wlen_in      = LW'(1);
               end
               CLS_OTHER: begin
                  b_v = 1'b1;
                  b   = make_res(K_NONE, pos_ff, PW'(1), ERR_UNEXPECTED);
               end
               default: ;
            endcase
         end

         if (pos_ff < PW'(MAX_SOURCE_BYTES)) begin
            pos_in = pos_ff + 1'b1;
         end
      end

      if (in_end) begin
         line_in = LINE_W'(1);
      end else if (line_up && line_ff != LINE_MAX) begin
         line_in = line_ff + 1'b1;
      end else begin
         line_in = line_ff;
      end
   end

   // pack results in emission order
   always_comb begin
      push_bundle       = '0;
      push_bundle.line  = line_ff;
      push_bundle.count = 2'(a0_v) + 2'(a1_v) + 2'(b_v);
      if (a0_v) begin
         push_bundle.res[0] = a0;
         if (a1_v) begin
            push_bundle.res[1] = a1;
            push_bundle.res[2] = b;
         end else begin
            push_bundle.res[1] = b;
         end
      end else begin
         push_bundle.res[0] = b;
      end
   end

   assign push_valid = accept && (push_bundle.count != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         pend_ff      <= OP_BANG;
         lex_start_ff <= '0;
         pos_ff       <= '0;
         line_ff      <= LINE_W'(1);
         prefix_ff    <= '0;
         wlen_ff      <= '0;
      end else begin
         mode_ff <= mode_in;
         if (accept) begin
            pend_ff      <= pend_in;
            lex_start_ff <= lex_start_in;
            pos_ff       <= pos_in;
            line_ff      <= line_in;
            prefix_ff    <= prefix_in;
            wlen_ff      <= wlen_in;
         end
      end
   end

endmodule

`default_nettype wire

[rtl/sts_queue.sv]
`default_nettype none

module sts_queue
   import sts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push_valid,
   input  wire bundle_type  push_bundle,
   output logic             full,
   output logic             head_valid,
   output bundle_type       head_bundle,
   input  wire logic        pop
);

   bundle_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]    count_ff, count_in;
   logic                    do_push, do_pop;

   assign full        = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign head_valid  = (count_ff != '0);
   assign head_bundle = mem_ff[rd_ptr_ff];
   assign do_push     = push_valid && !full;
   assign do_pop      = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_bundle;
      end
   end

endmodule

`default_nettype wire

[rtl/sts_back.sv]
`default_nettype none

module sts_back
   import sts_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          head_valid,
   input  wire bundle_type    head_bundle,
   output logic               pop,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [55:0]        rsp_tdata,
   output logic [6:0]         rsp_tuser,
   output logic               rsp_tlast
);

   logic [1:0]        idx_ff, idx_in;
   logic              valid_ff, valid_in;
   result_type        res_ff;
   logic [LINE_W-1:0] line_ff;
   logic              last_ff;
   result_type        cur;
   logic              cur_last;
   logic              load;

   always_comb begin
      case (idx_ff)
         2'd0:    cur = head_bundle.res[0];
         2'd1:    cur = head_bundle.res[1];
         default: cur = head_bundle.res[2];
      endcase
   end

   assign cur_last = (idx_ff == head_bundle.count - 1'b1);
   assign load     = head_valid && (!valid_ff || rsp_tready);
   assign pop      = load && cur_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         idx_in   = cur_last ? 2'd0 : idx_ff + 1'b1;
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff  <= cur;
         line_ff <= head_bundle.line;
         last_ff <= cur_last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {line_ff, res_ff.length, res_ff.start};
   assign rsp_tuser  = {res_ff.err, res_ff.kind};
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

[rtl/sts_checker.sv]
`default_nettype none

`include "source_token_scanner_top_defines.svh"

module sts_checker
   import sts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [55:0] rsp_tdata,
   input  wire logic [6:0]  rsp_tuser,
   input  wire logic        rsp_tlast
);

   logic [KIND_W-1:0]        kind;
   logic [ERR_W-1:0]         err;
   logic [TOKEN_FIELD_W-1:0] length;
   logic [LINE_W-1:0]        line;

   assign kind   = rsp_tuser[4:0];
   assign err    = rsp_tuser[6:5];
   assign length = rsp_tdata[39:20];
   assign line   = rsp_tdata[55:40];

   `STS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast),
      "stalled result transaction changed")

   `STS_ASSERT_NOW(a_err_kind, clock, reset, rsp_tvalid && err != ERR_NONE,
      kind == K_NONE, "error report without the no-token kind")

   `STS_ASSERT_NOW(a_kind_err, clock, reset, rsp_tvalid && kind == K_NONE,
      err != ERR_NONE, "no-token kind without an error code")

   `STS_ASSERT_NOW(a_eof_last, clock, reset, rsp_tvalid && kind == K_EOF,
      rsp_tlast && length == '0 && err == ERR_NONE, "EOF token malformed or not last")

   `STS_ASSERT_NOW(a_line_pos, clock, reset, rsp_tvalid,
      line != '0, "line number zero")

endmodule

bind source_token_scanner_top sts_checker u_sts_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
   import sts_pkg::*;

   typedef enum logic [1:0] {
      PH_RX_HEAVY,   // sender idles rarely, receiver stalls often
      PH_TX_HEAVY,   // the other way round
      PH_NO_IDLE
   } traffic_phase_type;

   typedef struct packed {
      logic [7:0]        src_byte;
      logic              eos;
      logic              drain;     // hold this byte until every token has come back
      traffic_phase_type phase;
   } source_item_type;

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic [TOKEN_FIELD_W-1:0] start;
      logic [TOKEN_FIELD_W-1:0] length;
      logic [LINE_W-1:0]        line;
      logic [ERR_W-1:0]         err;
      logic                     last;
   } token_type;

   localparam int unsigned SOURCE_LIMIT  = 1048576;
   localparam int          KEYWORD_CHARS = 6;
   localparam int          RANDOM_ITEMS  = 420;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [55:0] rsp_tdata;
   wire  [6:0]  rsp_tuser;
   wire         rsp_tlast;

   source_token_scanner_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------
   // Scanner prediction
   // ------------------------------------------------------------------
   scan_mode_type lx_mode;
   logic [2:0]    lx_op;
   int unsigned   lx_start;
   int unsigned   lx_pos;
   int unsigned   lx_line;
   logic [63:0]   lx_word;
   int            lx_word_len;

   token_type     run_tokens[$];
   token_type     expected_tokens[$];

   string keyword_text [NUM_KEYWORDS] = '{
      "else", "fun", "if", "return", "var", "number", "string"
   };

   task automatic lexer_clear();
      lx_mode     = MODE_IDLE;
      lx_op       = OP_BANG;
      lx_start    = 0;
      lx_pos      = 0;
      lx_line     = 1;
      lx_word     = '0;
      lx_word_len = 0;
   endtask

   function automatic logic [TOKEN_FIELD_W-1:0] sat_field(input int unsigned v);
      return (v > FIELD_MAX) ? FIELD_MAX : v[TOKEN_FIELD_W-1:0];
   endfunction

   function automatic int unsigned lexeme_span(input int unsigned stop_pos);
      return (stop_pos >= lx_start) ? stop_pos - lx_start : 0;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
             (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z);
   endfunction

   function automatic logic [KIND_W-1:0] operator_kind(input logic [2:0] op,
                                                       input logic doubled);
      case (op)
         OP_BANG:    return doubled ? K_BANG_EQUAL : K_BANG;
         OP_EQUAL:   return doubled ? K_EQUAL_EQUAL : K_EQUAL;
         OP_LESS:    return doubled ? K_LESS_EQUAL : K_LESS;
         OP_GREATER: return doubled ? K_GREATER_EQUAL : K_GREATER;
         default:    return K_SLASH;
      endcase
   endfunction

   // first matching keyword wins; words past the keep limit are plain identifiers
   function automatic logic [KIND_W-1:0] word_kind();
      logic [KIND_W-1:0] k;
      logic              found;
      k = K_IDENT;
      found = 1'b0;
      if (lx_word_len <= KEYWORD_CHARS) begin
         for (int i = 0; i < NUM_KEYWORDS; i++) begin
            if (!found && lx_word_len == KW_LEN[i] && lx_word == KW_TEXT[i]) begin
               k = KW_KIND[i];
               found = 1'b1;
            end
         end
      end
      return k;
   endfunction

   task automatic add_token(input logic [KIND_W-1:0] kind, input int unsigned start,
                            input int unsigned len, input logic [ERR_W-1:0] err);
      token_type t;
      t.kind   = kind;
      t.start  = sat_field(start);
      t.length = sat_field(len);
      t.line   = lx_line[LINE_W-1:0];
      t.err    = err;
      t.last   = 1'b0;
      if (run_tokens.size() < MAX_RESULTS) begin
         run_tokens = {run_tokens, t};
      end
   endtask

   task automatic bump_line();
      if (lx_line < LINE_MAX) begin
         lx_line++;
      end
   endtask

   task automatic open_operator(input logic [2:0] op, input int unsigned p);
      lx_op    = op;
      lx_mode  = MODE_OPER;
      lx_start = p;
   endtask

   task automatic start_from_idle(input logic [7:0] c, input int unsigned p);
      lx_mode = MODE_IDLE;
      case (c)
         CHAR_LPAREN:  add_token(K_LEFT_PAREN, p, 1, ERR_NONE);
         CHAR_RPAREN:  add_token(K_RIGHT_PAREN, p, 1, ERR_NONE);
         CHAR_LBRACE:  add_token(K_LEFT_BRACE, p, 1, ERR_NONE);
         CHAR_RBRACE:  add_token(K_RIGHT_BRACE, p, 1, ERR_NONE);
         CHAR_COMMA:   add_token(K_COMMA, p, 1, ERR_NONE);
         CHAR_MINUS:   add_token(K_MINUS, p, 1, ERR_NONE);
         CHAR_PLUS:    add_token(K_PLUS, p, 1, ERR_NONE);
         CHAR_SEMI:    add_token(K_SEMICOLON, p, 1, ERR_NONE);
         CHAR_COLON:   add_token(K_COLON, p, 1, ERR_NONE);
         CHAR_STAR:    add_token(K_STAR, p, 1, ERR_NONE);
         CHAR_BANG:    open_operator(OP_BANG, p);
         CHAR_EQUAL:   open_operator(OP_EQUAL, p);
         CHAR_LESS:    open_operator(OP_LESS, p);
         CHAR_GREATER: open_operator(OP_GREATER, p);
         CHAR_SLASH:   open_operator(OP_SLASH, p);
         CHAR_QUOTE: begin
            lx_mode  = MODE_STRING;
            lx_start = p + 1;
         end
         CHAR_SPACE, CHAR_CR, CHAR_TAB: ;
         CHAR_NL:      bump_line();
         default: begin
            if (is_digit(c)) begin
               lx_mode  = MODE_NUM_INT;
               lx_start = p;
            end else if (is_alpha(c)) begin
               lx_mode     = MODE_WORD;
               lx_start    = p;
               lx_word     = {56'd0, c};
               lx_word_len = 1;
            end else begin
               add_token(K_NONE, p, 1, ERR_UNEXPECTED);
            end
         end
      endcase
   endtask

   // Advance the scanner by one transaction and queue the tokens it yields.
   task automatic lex_byte(input logic [7:0] c, input logic eos);
      int unsigned p;
      logic        taken;
      token_type   t;
      p = lx_pos;
      taken = 1'b0;
      run_tokens.delete();
      if (eos) begin
         case (lx_mode)
            MODE_OPER:   add_token(operator_kind(lx_op, 1'b0), lx_start, 1, ERR_NONE);
            MODE_STRING: add_token(K_NONE, lx_start, lexeme_span(p), ERR_UNTERM_STR);
            MODE_NUM_INT, MODE_NUM_FRAC:
               add_token(K_NUMBER, lx_start, lexeme_span(p), ERR_NONE);
            MODE_NUM_DOT: begin
               add_token(K_NUMBER, lx_start, lexeme_span(p - 1), ERR_NONE);
               add_token(K_NONE, p - 1, 1, ERR_UNEXPECTED);
            end
            MODE_WORD:   add_token(word_kind(), lx_start, lexeme_span(p), ERR_NONE);
            default: ;
         endcase
         add_token(K_EOF, p, 0, ERR_NONE);
         lexer_clear();
      end else begin
         case (lx_mode)
            MODE_OPER: begin
               if (lx_op != OP_SLASH && c == CHAR_EQUAL) begin
                  add_token(operator_kind(lx_op, 1'b1), lx_start, 2, ERR_NONE);
                  lx_mode = MODE_IDLE;
                  taken = 1'b1;
               end else if (lx_op == OP_SLASH && c == CHAR_SLASH) begin
                  lx_mode = MODE_COMMENT;
                  taken = 1'b1;
               end else begin
                  add_token(operator_kind(lx_op, 1'b0), lx_start, 1, ERR_NONE);
                  lx_mode = MODE_IDLE;
               end
            end
            MODE_COMMENT: taken = (c != CHAR_NL);
            MODE_STRING: begin
               if (c == CHAR_QUOTE) begin
                  add_token(K_STRING, lx_start, lexeme_span(p), ERR_NONE);
                  lx_mode = MODE_IDLE;
               end else if (c == CHAR_NL) begin
                  bump_line();
               end
               taken = 1'b1;
            end
            MODE_NUM_INT: begin
               if (is_digit(c)) begin
                  taken = 1'b1;
               end else if (c == CHAR_DOT) begin
                  lx_mode = MODE_NUM_DOT;
                  taken = 1'b1;
               end else begin
                  add_token(K_NUMBER, lx_start, lexeme_span(p), ERR_NONE);
               end
            end
            MODE_NUM_DOT: begin
               if (is_digit(c)) begin
                  lx_mode = MODE_NUM_FRAC;
                  taken = 1'b1;
               end else begin
                  // number ends before the dot; the lone dot is reported
                  add_token(K_NUMBER, lx_start, lexeme_span(p - 1), ERR_NONE);
                  add_token(K_NONE, p - 1, 1, ERR_UNEXPECTED);
               end
            end
            MODE_NUM_FRAC: begin
               if (is_digit(c)) begin
                  taken = 1'b1;
               end else begin
                  add_token(K_NUMBER, lx_start, lexeme_span(p), ERR_NONE);
               end
            end
            MODE_WORD: begin
               if (is_digit(c) || is_alpha(c)) begin
                  if (lx_word_len < KEYWORD_CHARS) begin
                     lx_word[8*lx_word_len +: 8] = c;
                     lx_word_len++;
                  end else begin
                     lx_word_len = KEYWORD_CHARS + 1;
                  end
                  taken = 1'b1;
               end else begin
                  add_token(word_kind(), lx_start, lexeme_span(p), ERR_NONE);
               end
            end
            default: ;
         endcase
         if (!taken) begin
            start_from_idle(c, p);
         end
         if (lx_pos < SOURCE_LIMIT) begin
            lx_pos++;
         end
      end
      for (int i = 0; i < run_tokens.size(); i++) begin
         t = run_tokens[i];
         t.last = (i == run_tokens.size() - 1);
         expected_tokens = {expected_tokens, t};
      end
   endtask

   // ------------------------------------------------------------------
   // Source driver
   // ------------------------------------------------------------------
   source_item_type   source_stream[$];
   traffic_phase_type rx_phase = PH_RX_HEAVY;
   int unsigned       bytes_fed = 0;
   int unsigned       sources_fed = 0;

   always @(posedge clock) begin
      logic send;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            lex_byte(source_stream[0].src_byte, source_stream[0].eos);
            if (source_stream[0].eos) begin
               sources_fed++;
            end else begin
               bytes_fed++;
            end
            void'(source_stream.pop_front());
         end
         // a presented transaction stays put until it is taken
         if (!req_tvalid || req_tready) begin
            send = 1'b0;
            if (source_stream.size() != 0) begin
               send = !(source_stream[0].drain && expected_tokens.size() != 0);
               case (source_stream[0].phase)
                  PH_RX_HEAVY: if ($urandom_range(99) < 11) send = 1'b0;
                  PH_TX_HEAVY: if ($urandom_range(99) < 72) send = 1'b0;
                  default: ;
               endcase
            end
            req_tvalid <= send;
            if (send) begin
               req_tdata <= source_stream[0].src_byte;
               req_tlast <= source_stream[0].eos;
               rx_phase  <= source_stream[0].phase;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Token monitor
   // ------------------------------------------------------------------
   int unsigned fail_count = 0;
   int unsigned tokens_checked = 0;
   int unsigned error_reports = 0;

   task automatic log_failure(input string what);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t: %s", $realtime, what);
      end
   endtask

   always @(posedge clock) begin
      token_type got;
      token_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind   = rsp_tuser[4:0];
            got.err    = rsp_tuser[6:5];
            got.start  = rsp_tdata[19:0];
            got.length = rsp_tdata[39:20];
            got.line   = rsp_tdata[55:40];
            got.last   = rsp_tlast;
            if (got.err != ERR_NONE) begin
               error_reports++;
            end
            if (expected_tokens.size() == 0) begin
               log_failure($sformatf("token with nothing pending: kind %0d start %0d",
                                     got.kind, got.start));
            end else begin
               want = expected_tokens.pop_front();
               tokens_checked++;
               if (got.kind !== want.kind || got.start !== want.start ||
                   got.length !== want.length || got.line !== want.line ||
                   got.err !== want.err || got.last !== want.last) begin
                  log_failure($sformatf({"token mismatch: expected kind %0d start %0d ",
                     "len %0d line %0d err %0d last %0b; got kind %0d start %0d ",
                     "len %0d line %0d err %0d last %0b"},
                     want.kind, want.start, want.length, want.line, want.err, want.last,
                     got.kind, got.start, got.length, got.line, got.err, got.last));
               end
            end
         end
         case (rx_phase)
            PH_RX_HEAVY: rsp_tready <= ($urandom_range(99) >= 72);
            PH_TX_HEAVY: rsp_tready <= ($urandom_range(99) >= 11);
            default:     rsp_tready <= 1'b1;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   traffic_phase_type gen_phase = PH_RX_HEAVY;
   logic              gen_drain = 1'b0;

   task automatic put_byte(input logic [7:0] b, input logic eos);
      source_item_type it;
      it.src_byte = b;
      it.eos      = eos;
      it.drain    = gen_drain;
      it.phase    = gen_phase;
      gen_drain   = 1'b0;
      source_stream = {source_stream, it};
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         put_byte(s[i], 1'b0);
      end
   endtask

   task automatic put_eof();
      put_byte(8'($urandom_range(255)), 1'b1);
   endtask

   function automatic logic [7:0] rand_letter();
      if ($urandom_range(1)) begin
         return 8'(CHAR_LOWER_A + $urandom_range(25));
      end
      return 8'(CHAR_UPPER_A + $urandom_range(25));
   endfunction

   function automatic logic [7:0] rand_body_byte(input logic [7:0] stop_char);
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(255));
      end while (b == stop_char);
      return b;
   endfunction

   task automatic put_digits(input int n);
      repeat (n) put_byte(8'(CHAR_ZERO + $urandom_range(9)), 1'b0);
   endtask

   // mostly well-formed lexemes with random content, some noise and broken ones
   task automatic put_random_token();
      int         sel;
      int         n;
      string      s;
      logic [7:0] b;
      sel = $urandom_range(99);
      if (sel < 12) begin
         s = "(){},-+;:*";
         put_byte(s[$urandom_range(9)], 1'b0);
      end else if (sel < 24) begin
         s = "!=<>/";
         n = $urandom_range(4);
         put_byte(s[n], 1'b0);
         if (n < 4 && $urandom_range(1)) begin
            put_byte(CHAR_EQUAL, 1'b0);
         end
      end else if (sel < 31) begin
         put_text("//");
         repeat ($urandom_range(6)) put_byte(rand_body_byte(CHAR_NL), 1'b0);
         put_byte(CHAR_NL, 1'b0);
      end else if (sel < 41) begin
         put_byte(CHAR_QUOTE, 1'b0);
         repeat ($urandom_range(6)) put_byte(rand_body_byte(CHAR_QUOTE), 1'b0);
         put_byte(CHAR_QUOTE, 1'b0);
      end else if (sel < 52) begin
         put_digits($urandom_range(1, 4));
         if ($urandom_range(1)) begin
            put_byte(CHAR_DOT, 1'b0);
            put_digits($urandom_range(1, 3));
         end
      end else if (sel < 63) begin
         put_text(keyword_text[$urandom_range(NUM_KEYWORDS - 1)]);
         if ($urandom_range(3) == 0) begin
            put_byte(rand_letter(), 1'b0);
         end
      end else if (sel < 72) begin
         put_byte(rand_letter(), 1'b0);
         repeat ($urandom_range(9)) begin
            if ($urandom_range(3) == 0) begin
               put_digits(1);
            end else begin
               put_byte(rand_letter(), 1'b0);
            end
         end
      end else if (sel < 82) begin
         case ($urandom_range(3))
            0: put_byte(CHAR_SPACE, 1'b0);
            1: put_byte(CHAR_TAB, 1'b0);
            2: put_byte(CHAR_CR, 1'b0);
            default: put_byte(CHAR_NL, 1'b0);
         endcase
      end else if (sel < 89) begin
         put_byte(8'($urandom_range(255)), 1'b0);
      end else if (sel < 95) begin
         // number whose dot is left without a digit
         put_digits($urandom_range(1, 3));
         put_byte(CHAR_DOT, 1'b0);
         if ($urandom_range(3) == 0) begin
            put_eof();
         end
      end else begin
         put_byte(CHAR_QUOTE, 1'b0);
         repeat ($urandom_range(4)) put_byte(rand_body_byte(CHAR_QUOTE), 1'b0);
         put_eof();
      end
      if ($urandom_range(1)) begin
         put_byte(CHAR_SPACE, 1'b0);
      end
      if ($urandom_range(29) == 0) begin
         put_eof();
      end
   endtask

   initial begin
      int base;
      int n;
      lexer_clear();

      // directed: all punctuation, operator chains, dot without digit,
      // non-ASCII byte, then an unterminated string and a number left on a dot
      put_text("(){},-+;:*!<>=/1.a");
      put_byte(8'hFF, 1'b0);
      put_eof();
      put_text("\"ab");
      put_eof();
      put_text("7.");
      put_eof();

      base = source_stream.size();
      while (source_stream.size() - base < RANDOM_ITEMS) begin
         n = source_stream.size() - base;
         if (n >= 2 * RANDOM_ITEMS / 3) begin
            gen_phase = PH_NO_IDLE;
         end else if (n >= RANDOM_ITEMS / 3 && gen_phase == PH_RX_HEAVY) begin
            gen_phase = PH_TX_HEAVY;
            gen_drain = 1'b1;
         end
         put_random_token();
      end
      put_eof();

      @(negedge clock);
      while (reset || source_stream.size() != 0 || req_tvalid) @(negedge clock);
      while (expected_tokens.size() != 0) @(negedge clock);
      repeat (16) @(negedge clock);

      $display("Fed %0d source bytes and %0d end markers; compared %0d tokens (%0d errors).",
               bytes_fed, sources_fed, tokens_checked, error_reports);
      $display("Mixed back-pressure and idle patterns, one drain pause, broken lexemes.");
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d failures", fail_count);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout: %0d tokens still pending", expected_tokens.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
